// File: rtl/nmeachk_pkg.sv
// Shared types, character codes and helpers for the NMEA line checker.
// Depends on nothing; imported by nmea_sentence_checker, nmea_sentence_verify and nmea_sentence_checker_tb.
package nmeachk_pkg;

    // Default size of the line buffer in bytes; one slot is kept for a terminator
    localparam int LINE_BUFFER_BYTES_DEF = 100;

    // Width of the consecutive invalid line counter and of the limit register
    localparam int RUN_W   = 8;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] GARBAGE_LIMIT_RST = 7'd100;

    // Number of header bytes kept from the start character on
    localparam int HDR_LEN = 6;
    localparam int HDR_CNT_W = 3;

    // Character codes
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CH_DOLL  = 8'h24;  // '$'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_C     = 8'h43;  // 'C'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Six-byte headers, first character in the top byte
    localparam logic [8*HDR_LEN-1:0] HDR_AIS = "!AIVDM";
    localparam logic [8*HDR_LEN-1:0] HDR_RMC = "$GPRMC";
    localparam logic [8*HDR_LEN-1:0] HDR_MWV = "$WIMWV";
    localparam logic [8*HDR_LEN-1:0] HDR_XDR = "$WIXDR";

    // Sentence kind codes
    localparam logic [2:0] KIND_OTHER   = 3'd0;
    localparam logic [2:0] KIND_AIS     = 3'd1;
    localparam logic [2:0] KIND_RMC     = 3'd2;
    localparam logic [2:0] KIND_MWV     = 3'd3;
    localparam logic [2:0] KIND_XDR     = 3'd4;
    localparam logic [2:0] KIND_COMPASS = 3'd5;

    // Line parser phase
    typedef enum logic [7:0] {
        PH_HUNT  = 8'b0000_0001,
        PH_SUM   = 8'b0000_0010,
        PH_HEX1  = 8'b0000_0100,
        PH_HEX2  = 8'b0000_1000,
        PH_TAIL1 = 8'b0001_0000,
        PH_TAIL2 = 8'b0010_0000,
        PH_GOOD  = 8'b0100_0000,
        PH_BAD   = 8'b1000_0000
    } t_phase;

    // One result beat
    typedef struct packed {
        logic       ok;
        logic [2:0] kind;
        logic [7:0] csum;
        logic       alarm;
    } t_result;

    // Uppercase hex character for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'd0, v};
        end else begin
            c = 8'h41 + {4'd0, v} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: rtl/nmea_sentence_checker.sv
// Top level of the NMEA 0183 line checker: framing, checksum, sentence class, alarm.
// Depends on nmeachk_pkg for character codes, the phase type and the result beat.

// The block takes one received character per clock and cuts the stream into
// lines, ending a line at LF or when it holds LINE_BUFFER_BYTES-1 bytes. Each
// finished line gives one result beat: sentence_ok, sentence_kind (valid lines
// only), the XOR checksum computed over the bytes after '!' or '$' up to '*',
// and garbage_alarm, raised while the run of consecutive invalid lines exceeds
// garbage_limit. Every input beat is handled in the cycle it is accepted, so
// the sustained rate is one character per cycle; the result of a line is
// registered into the output register as its last character is accepted,
// unless an earlier result is still waiting there. Results pass through a
// two-entry output buffer, and the input stalls only while both entries are
// full. Write garbage_limit only while no line result is pending.
module nmea_sentence_checker
    import nmeachk_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_garbage_limit,
    // character input
    input  logic               i_rx_valid,
    output logic               o_rx_stall,
    input  logic [7:0]         i_rx_byte,
    // line result output
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic               o_sentence_ok,
    output logic [2:0]         o_sentence_kind,
    output logic [7:0]         o_computed_checksum,
    output logic               o_garbage_alarm
);

    localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUFFER_BYTES - 2);

    // Line state
    t_phase               r_phase, n_phase;
    logic [7:0]           r_xor, n_xor;
    logic [7:0]           r_hdr [HDR_LEN];
    logic [7:0]           n_hdr [HDR_LEN];
    logic [HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [LEN_W-1:0]     r_len;
    logic [RUN_W-1:0]     r_run, n_run;
    logic [LIMIT_W-1:0]   r_limit;

    // Output buffer
    t_result r_out, r_skid, w_res;
    logic    r_out_valid, r_skid_valid;

    logic                   w_rx_acc, w_out_take, w_line_end, w_tail_ok;
    logic [8*HDR_LEN-1:0]   w_hdr_vec;
    logic [2:0]             w_kind;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = r_skid_valid;
    assign w_rx_acc    = i_rx_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_res_stall;

    // Advance the parser by one character
    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_hdr     = r_hdr;
        n_hdr_cnt = r_hdr_cnt;
        if (r_phase == PH_HUNT) begin
            if (i_rx_byte == CH_BANG || i_rx_byte == CH_DOLL) begin
                n_phase   = PH_SUM;
                n_xor     = '0;
                n_hdr[0]  = i_rx_byte;
                n_hdr_cnt = HDR_CNT_W'(1);
            end
        end else begin
            if (r_hdr_cnt < HDR_CNT_W'(HDR_LEN)) begin
                n_hdr[r_hdr_cnt] = i_rx_byte;
                n_hdr_cnt        = r_hdr_cnt + HDR_CNT_W'(1);
            end
            unique case (r_phase)
                PH_SUM: begin
                    if (i_rx_byte == CH_STAR) begin
                        n_phase = PH_HEX1;
                    end else begin
                        n_xor = r_xor ^ i_rx_byte;
                    end
                end
                PH_HEX1: begin
                    n_phase = (i_rx_byte == hex_char(r_xor[7:4])) ? PH_HEX2 : PH_BAD;
                end
                PH_HEX2: begin
                    n_phase = (i_rx_byte == hex_char(r_xor[3:0])) ? PH_TAIL1 : PH_BAD;
                end
                PH_TAIL1: begin
                    if (i_rx_byte == CH_CR) begin
                        n_phase = PH_TAIL2;
                    end else if (i_rx_byte == CH_LF) begin
                        n_phase = PH_GOOD;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_TAIL2: begin
                    n_phase = (i_rx_byte == CH_LF) ? PH_GOOD : PH_BAD;
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase
        end
    end

    assign w_tail_ok  = (n_phase == PH_TAIL2) || (n_phase == PH_GOOD);
    assign w_line_end = (i_rx_byte == CH_LF) || (r_len == LEN_LAST);
    assign w_hdr_vec  = {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3], n_hdr[4], n_hdr[5]};

    // Classify the line by its header
    always_comb begin
        w_kind = KIND_OTHER;
        if (w_tail_ok) begin
            if (n_hdr_cnt == HDR_CNT_W'(HDR_LEN) && w_hdr_vec == HDR_AIS) begin
                w_kind = KIND_AIS;
            end else if (n_hdr_cnt == HDR_CNT_W'(HDR_LEN) && w_hdr_vec == HDR_RMC) begin
                w_kind = KIND_RMC;
            end else if (n_hdr_cnt == HDR_CNT_W'(HDR_LEN) && w_hdr_vec == HDR_MWV) begin
                w_kind = KIND_MWV;
            end else if (n_hdr_cnt == HDR_CNT_W'(HDR_LEN) && w_hdr_vec == HDR_XDR) begin
                w_kind = KIND_XDR;
            end else if (n_hdr_cnt >= HDR_CNT_W'(3) && n_hdr[0] == CH_DOLL
                         && n_hdr[1] == CH_C && n_hdr[2] >= CH_0 && n_hdr[2] <= CH_9) begin
                w_kind = KIND_COMPASS;
            end
        end
    end

    // Count invalid lines in a row, saturating
    always_comb begin
        if (w_tail_ok) begin
            n_run = '0;
        end else if (r_run == {RUN_W{1'b1}}) begin
            n_run = r_run;
        end else begin
            n_run = r_run + RUN_W'(1);
        end
    end

    assign w_res.ok    = w_tail_ok;
    assign w_res.kind  = w_kind;
    assign w_res.csum  = n_xor;
    assign w_res.alarm = n_run > {1'b0, r_limit};

    // Hold the garbage limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= GARBAGE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_garbage_limit;
        end
    end

    // Update line state per accepted beat; clear it at the end of a line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_xor     <= '0;
            r_hdr_cnt <= '0;
            r_len     <= '0;
            r_run     <= '0;
        end else if (w_rx_acc) begin
            if (w_line_end) begin
                r_phase   <= PH_HUNT;
                r_xor     <= '0;
                r_hdr_cnt <= '0;
                r_len     <= '0;
                r_run     <= n_run;
            end else begin
                r_phase   <= n_phase;
                r_xor     <= n_xor;
                r_hdr_cnt <= n_hdr_cnt;
                r_len     <= r_len + LEN_W'(1);
            end
        end
    end

    // Header bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (w_rx_acc) begin
            r_hdr <= n_hdr;
        end
    end

    // Two-entry output buffer: main register plus skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_rx_acc && w_line_end) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_rx_acc && w_line_end) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_sentence_ok       = r_out.ok;
    assign o_sentence_kind     = r_out.kind;
    assign o_computed_checksum = r_out.csum;
    assign o_garbage_alarm     = r_out.alarm;

endmodule

// File: tb/sv/nmea_sentence_verify.sv
// Line predictor and result compare for the nmea_sentence_checker testbench.
// Depends on nmeachk_pkg for character codes, header words, kinds and the phase type.
`timescale 1ns / 100ps

module nmea_sentence_verify
    import nmeachk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_garbage_limit,
    input  logic               i_rx_valid,
    input  logic               i_rx_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic               i_sentence_ok,
    input  logic [2:0]         i_sentence_kind,
    input  logic [7:0]         i_computed_checksum,
    input  logic               i_garbage_alarm,
    output int                 o_mismatches,
    output int                 o_lines_due
);

    localparam int LINE_MAX = LINE_BUFFER_BYTES_DEF - 1;

    // Shadow of the line parser
    t_phase               line_phase;
    logic [7:0]           line_xor;
    logic [7:0]           hdr_chars [HDR_LEN];
    logic [HDR_CNT_W-1:0] hdr_cnt;
    int                   line_len;
    logic [RUN_W-1:0]     bad_run;
    logic [LIMIT_W-1:0]   limit_reg;

    // Verdicts of finished lines, oldest first
    t_result              line_verdicts[$];
    int                   mismatch_count = 0;

    // Uppercase hex character of one nibble
    function automatic logic [7:0] upper_hex(input logic [3:0] nib);
        return (nib > 4'd9) ? 8'h37 + 8'(nib) : CH_0 + 8'(nib);
    endfunction

    // Class a good line by its leading characters
    function automatic logic [2:0] line_kind();
        logic [8*HDR_LEN-1:0] word;
        word = '0;
        if (hdr_cnt == HDR_CNT_W'(HDR_LEN)) begin
            for (int i = 0; i < HDR_LEN; i++) word = {word[8*HDR_LEN-9:0], hdr_chars[i]};
            if (word == HDR_AIS) return KIND_AIS;
            if (word == HDR_RMC) return KIND_RMC;
            if (word == HDR_MWV) return KIND_MWV;
            if (word == HDR_XDR) return KIND_XDR;
        end
        if (hdr_cnt >= 3 && hdr_chars[0] == CH_DOLL && hdr_chars[1] == CH_C &&
            hdr_chars[2] >= CH_0 && hdr_chars[2] <= CH_9) begin
            return KIND_COMPASS;
        end
        return KIND_OTHER;
    endfunction

    function automatic void clear_line();
        line_phase = PH_HUNT;
        line_xor   = 8'h00;
        hdr_cnt    = '0;
        line_len   = 0;
    endfunction

    // Advance the parser by one accepted character, close the line at LF or full buffer
    function automatic void take_char(input logic [7:0] c);
        t_result verdict;
        logic    tail_good;
        line_len++;
        if (line_phase == PH_HUNT) begin
            if (c == CH_BANG || c == CH_DOLL) begin
                line_phase   = PH_SUM;
                line_xor     = 8'h00;
                hdr_chars[0] = c;
                hdr_cnt      = HDR_CNT_W'(1);
            end
        end else begin
            if (hdr_cnt < HDR_LEN) begin
                hdr_chars[hdr_cnt] = c;
                hdr_cnt++;
            end
            case (line_phase)
                PH_SUM: begin
                    if (c == CH_STAR) line_phase = PH_HEX1;
                    else line_xor ^= c;
                end
                PH_HEX1: line_phase = (c == upper_hex(line_xor[7:4])) ? PH_HEX2 : PH_BAD;
                PH_HEX2: line_phase = (c == upper_hex(line_xor[3:0])) ? PH_TAIL1 : PH_BAD;
                PH_TAIL1: begin
                    if (c == CH_CR) line_phase = PH_TAIL2;
                    else if (c == CH_LF) line_phase = PH_GOOD;
                    else line_phase = PH_BAD;
                end
                PH_TAIL2: line_phase = (c == CH_LF) ? PH_GOOD : PH_BAD;
                default: line_phase = PH_BAD;
            endcase
        end

        if (c == CH_LF || line_len >= LINE_MAX) begin
            tail_good    = (line_phase == PH_TAIL2) || (line_phase == PH_GOOD);
            verdict.ok   = tail_good;
            verdict.kind = KIND_OTHER;
            if (tail_good) begin
                bad_run      = '0;
                verdict.kind = line_kind();
            end else if (bad_run != '1) begin
                bad_run++;
            end
            verdict.csum  = line_xor;
            verdict.alarm = (bad_run > {1'b0, limit_reg});
            line_verdicts.push_back(verdict);
            clear_line();
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            limit_reg = GARBAGE_LIMIT_RST;
            bad_run   = '0;
            clear_line();
            line_verdicts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) limit_reg = i_cfg_garbage_limit;
            if (i_res_valid && !i_res_stall) begin
                if (line_verdicts.size() == 0) begin
                    $error("result beat with no finished line waiting");
                    mismatch_count++;
                end else begin
                    want = line_verdicts.pop_front();
                    check_field("sentence_ok", 8'(want.ok), 8'(i_sentence_ok));
                    check_field("sentence_kind", 8'(want.kind), 8'(i_sentence_kind));
                    check_field("computed_checksum", want.csum, i_computed_checksum);
                    check_field("garbage_alarm", 8'(want.alarm), 8'(i_garbage_alarm));
                end
            end
            if (i_rx_valid && !i_rx_stall) take_char(i_rx_byte);
        end
        o_mismatches <= mismatch_count;
        o_lines_due  <= line_verdicts.size();
    end

endmodule

// File: tb/sv/nmea_sentence_checker_tb.sv
// Testbench top for nmea_sentence_checker: drives characters and limit writes,
// stalls the result side at random and prints the verdict.
// Depends on nmeachk_pkg and nmea_sentence_verify, which predicts and compares.
`timescale 1ns / 100ps

module nmea_sentence_checker_tb;
    import nmeachk_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LINE_MAX      = LINE_BUFFER_BYTES_DEF - 1;
    localparam int RANDOM_CHARS  = 150;
    localparam int BURST_LINES   = 280;

    // Ways to spoil an otherwise good sentence
    typedef enum int {
        INTACT, LOWER_HEX, WRONG_SUM, TRAILING_BYTE, NO_STAR, DOUBLE_CR, SHORT_TAIL
    } t_damage;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_limit = '0;
    logic               rx_valid  = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte   = 8'h00;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic               sentence_ok;
    logic [2:0]         sentence_kind;
    logic [7:0]         computed_checksum;
    logic               garbage_alarm;

    int                 mismatches;
    int                 lines_due;
    bit                 steady      = 1'b0;
    int                 line_fill   = 0;
    int                 chars_sent  = 0;
    int unsigned        cycle_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    nmea_sentence_checker dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_garbage_limit (cfg_limit),
        .i_rx_valid          (rx_valid),
        .o_rx_stall          (rx_stall),
        .i_rx_byte           (rx_byte),
        .o_res_valid         (res_valid),
        .i_res_stall         (res_stall),
        .o_sentence_ok       (sentence_ok),
        .o_sentence_kind     (sentence_kind),
        .o_computed_checksum (computed_checksum),
        .o_garbage_alarm     (garbage_alarm)
    );

    nmea_sentence_verify u_verify (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_garbage_limit (cfg_limit),
        .i_rx_valid          (rx_valid),
        .i_rx_stall          (rx_stall),
        .i_rx_byte           (rx_byte),
        .i_res_valid         (res_valid),
        .i_res_stall         (res_stall),
        .i_sentence_ok       (sentence_ok),
        .i_sentence_kind     (sentence_kind),
        .i_computed_checksum (computed_checksum),
        .i_garbage_alarm     (garbage_alarm),
        .o_mismatches        (mismatches),
        .o_lines_due         (lines_due)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_0 + 8'(v) : "A" + 8'(v) - 8'd10;
    endfunction

    // Sentence body byte: mostly printable, sometimes any value but '*' and LF
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        c = CH_STAR;
        while (c == CH_STAR || c == CH_LF) begin
            if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
            else c = 8'($urandom_range(8'h20, 8'h7E));
        end
        return c;
    endfunction

    // Noise byte that neither starts a sentence nor ends a line
    function automatic logic [7:0] lead_char();
        logic [7:0] c;
        c = CH_LF;
        while (c == CH_LF || c == CH_BANG || c == CH_DOLL) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Stall the result side in random bursts
    initial begin
        int n;
        forever begin
            n = steady ? 0 : gap_len();
            if (n > 0) begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Hold off, then present one character until the beat is taken
    task automatic send_char(input logic [7:0] c);
        int n;
        n = steady ? 0 : gap_len();
        if (n > 0) begin
            rx_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        line_fill = (c == CH_LF || line_fill + 1 >= LINE_MAX) ? 0 : line_fill + 1;
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // Drop valid and wait for every finished line to report
    task automatic drain(input int extra);
        rx_valid <= 1'b0;
        @(posedge clk);
        while (lines_due != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_limit <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One sentence with random header, body and tail, sometimes spoiled
    task automatic send_sentence();
        logic [7:0]           q[$];
        logic [8*HDR_LEN-1:0] head;
        logic [7:0]           sum, hi, lo, c;
        int                   hlen;
        t_damage              damage;
        sum  = 8'h00;
        hlen = HDR_LEN;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) q.push_back(lead_char());
        end
        case ($urandom_range(0, 10))
            0: head = HDR_AIS;
            1: head = HDR_RMC;
            2: head = HDR_MWV;
            3: head = HDR_XDR;
            4: begin
                head = {CH_DOLL, CH_C, 8'(CH_0 + $urandom_range(0, 9)), 24'h0};
                hlen = 3;
            end
            5: begin
                head = {CH_DOLL, CH_C, body_char(), 24'h0};
                hlen = 3;
            end
            6: head = "$GPGGA";
            7: head = "!AIVDO";
            8: begin
                head = {CH_DOLL, 40'h0};
                hlen = 1;
            end
            9: begin
                head = {CH_BANG, 40'h0};
                hlen = 1;
            end
            default: begin
                head = {CH_DOLL, CH_C, 32'h0};
                hlen = 2;
            end
        endcase
        for (int i = 0; i < hlen; i++) begin
            c = head[8*(HDR_LEN-1-i) +: 8];
            q.push_back(c);
            if (i > 0) sum ^= c;
        end
        repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20)) begin
            c = body_char();
            q.push_back(c);
            sum ^= c;
        end

        hi = nibble_char(sum[7:4]);
        lo = nibble_char(sum[3:0]);
        damage = ($urandom_range(0, 4) == 0) ? t_damage'($urandom_range(LOWER_HEX, SHORT_TAIL))
                                             : INTACT;
        if (damage == LOWER_HEX) begin
            if (hi >= "A" && hi <= "F") hi = hi | 8'h20;
            if (lo >= "A" && lo <= "F") lo = lo | 8'h20;
        end
        if (damage == WRONG_SUM) lo = lo ^ 8'h01;
        if (damage != NO_STAR) q.push_back(CH_STAR);
        if (damage != SHORT_TAIL) begin
            q.push_back(hi);
            q.push_back(lo);
        end
        if ($urandom_range(0, 1) == 1) q.push_back(CH_CR);
        if (damage == DOUBLE_CR) q.push_back(CH_CR);
        if (damage == TRAILING_BYTE) q.push_back(lead_char());
        q.push_back(CH_LF);
        foreach (q[i]) send_char(q[i]);
    endtask

    // Lines that fill the buffer: checksum ending on the last slot, or plain overflow
    task automatic send_full_line();
        logic [7:0] q[$];
        logic [7:0] sum, c;
        int         body;
        if (line_fill != 0) send_char(CH_LF);
        if ($urandom_range(0, 2) == 0) begin
            repeat (LINE_MAX + $urandom_range(0, 40)) send_char(lead_char());
            send_char(CH_LF);
        end else begin
            // CR lands on the last slot, or the low hex digit does
            body = ($urandom_range(0, 1) == 0) ? LINE_MAX - 5 : LINE_MAX - 4;
            sum  = 8'h00;
            q.push_back(CH_DOLL);
            repeat (body) begin
                c = body_char();
                q.push_back(c);
                sum ^= c;
            end
            q.push_back(CH_STAR);
            q.push_back(nibble_char(sum[7:4]));
            q.push_back(nibble_char(sum[3:0]));
            if (body == LINE_MAX - 5) q.push_back(CH_CR);
            if ($urandom_range(0, 1) == 1) q.push_back(CH_LF);
            foreach (q[i]) send_char(q[i]);
        end
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(0, 3)) send_char(lead_char());
        send_char(CH_LF);
    endtask

    // Mixed traffic until the character budget is spent, then drain
    task automatic run_random(input int chars);
        int stop;
        stop = chars_sent + chars;
        while (chars_sent < stop) begin
            if ($urandom_range(0, 11) == 0) steady = !steady;
            case ($urandom_range(0, 19))
                0: send_full_line();
                1, 2: send_noise_line();
                3: drain(0);
                default: send_sentence();
            endcase
        end
        steady = 1'b0;
        if (line_fill != 0) send_char(CH_LF);
        drain(SETTLE_CYCLES);
    endtask

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Lone LF, CR LF tail, NUL and a second start character, lowercase hex, byte after tail
        send_char(CH_LF);
        send_text("$*00\r\n");
        send_char(CH_DOLL);
        send_char(8'h00);
        send_text("$*24\n");
        send_text("$:*3a\n");
        send_text("!*00X\n");
        drain(SETTLE_CYCLES);

        // Alarm on the first bad line
        write_limit('0);
        run_random(RANDOM_CHARS);

        // Long run of bad lines: alarm past the top limit, then saturate the run count
        write_limit('1);
        steady = 1'b1;
        repeat (BURST_LINES) send_char(CH_LF);
        steady = 1'b0;
        repeat (4) send_sentence();
        drain(SETTLE_CYCLES);

        write_limit(LIMIT_W'($urandom_range(1, 126)));
        run_random(RANDOM_CHARS);

        write_limit(GARBAGE_LIMIT_RST);
        run_random(RANDOM_CHARS);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
